// ===== rtl/core/quaternion_to_rotation_matrix_defines.svh =====
// Assertion macros for the quaternion to rotation matrix block.
// Used by the port-level checker; needs clk and arst_n in scope.
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define QRM_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Implication checked at every clock edge out of reset
`define QRM_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/qrm_pkg.sv =====
// Shared types, widths and constants for the quaternion to rotation matrix block.
// No dependencies.
`timescale 1ns / 1ps
package qrm_pkg;

	// Component width of the input quaternion (8..32)
	localparam int COMPONENT_WIDTH = 16;
	localparam int CW = COMPONENT_WIDTH;

	// Magnitudes above this are pre-scaled so products stay in range
	localparam longint unsigned MAG_LIMIT = 64'd8388608;
	localparam int SH_MAX = (CW > 24) ? (CW - 24) : 0;
	localparam int SHW = 4;

	// Magnitude width after pre-scaling, product, norm widths
	localparam int MW = (CW > 24) ? 24 : CW;
	localparam int PRW = 2 * MW;
	localparam int SPW = PRW + 1;
	localparam int NW = PRW + 1;

	// Quotient bits of a * 2^16 / n, one per divider stage
	localparam int QB = 17;

	// Front pipeline depth plus divider depth plus output register
	localparam int FRONT_STAGES = 3;
	localparam int LATENCY = FRONT_STAGES + QB + 1;

	// Q2.14 constants
	localparam logic [15:0] ONE_Q14 = 16'd16384;
	localparam logic [QB-1:0] ONE_Q = QB'(16384);
	localparam logic [QB-1:0] TWO_Q = QB'(32768);

	// Matrix entries on the diagonal, rows first
	localparam logic [8:0] DIAG_MASK = 9'b100010001;

	typedef struct packed {
		logic signed [CW-1:0] comp_x;
		logic signed [CW-1:0] comp_y;
		logic signed [CW-1:0] comp_z;
		logic signed [CW-1:0] comp_w;
	} in_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		logic               degenerate;
	} out_t;

	// Front end output: norm, nine numerator magnitudes and signs
	typedef struct packed {
		logic                 deg;
		logic [NW-1:0]        n;
		logic [8:0][NW-1:0]   num;
		logic [8:0]           neg;
	} front_t;

endpackage

// ===== rtl/core/quaternion_to_rotation_matrix.sv =====
// Quaternion to 3x3 rotation matrix, rows first, Q2.14 entries.
// A new quaternion is taken every cycle (busy is never high) and its matrix
// appears with done after three front stages (magnitudes,
// products, norm), seventeen divider stages that each settle one quotient
// bit of numerator * 2^16 / norm, and the output register. An all-zero input
// gives the identity matrix with degenerate set. Results cannot be held off.
// Depends on qrm_pkg, qrm_front, qrm_divider.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix import qrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic done,
	output out_t result
);

	logic          fr_valid;
	front_t        fr;
	logic [QB-1:0] quo [9];

	logic          vld_d [QB];
	logic          deg_d [QB];
	logic [8:0]    neg_d [QB];

	logic [15:0]   ent [9];
	logic          done_q;
	out_t          result_q;

	assign busy = 1'b0;

	qrm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.item     (item),
		.out_valid(fr_valid),
		.out_data (fr)
	);

	for (genvar e = 0; e < 9; e++) begin : g_lane
		qrm_divider u_div (
			.clk(clk),
			.num(fr.num[e]),
			.den(fr.n),
			.quo(quo[e])
		);
	end

	// Side band travels alongside the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QB; k++)
				vld_d[k] <= 1'b0;
		end else begin
			vld_d[0] <= fr_valid;
			for (int k = 1; k < QB; k++)
				vld_d[k] <= vld_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		deg_d[0] <= fr.deg;
		neg_d[0] <= fr.neg;
		for (int k = 1; k < QB; k++) begin
			deg_d[k] <= deg_d[k-1];
			neg_d[k] <= neg_d[k-1];
		end
	end

	// Round half up, clamp, apply sign or subtract from one; degenerate gives identity
	always_comb begin
		logic [QB:0]   rsum;
		logic [QB-1:0] r;
		for (int e = 0; e < 9; e++) begin
			rsum = {1'b0, quo[e]} + 1'b1;
			r = rsum[QB:1];
			if (DIAG_MASK[e]) begin
				if (r > TWO_Q)
					r = TWO_Q;
				ent[e] = ONE_Q14 - 16'(r);
			end else begin
				if (r > ONE_Q)
					r = ONE_Q;
				ent[e] = neg_d[QB-1][e] ? (~16'(r) + 1'b1) : 16'(r);
			end
			if (deg_d[QB-1])
				ent[e] = DIAG_MASK[e] ? ONE_Q14 : '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_d[QB-1];
	end

	always_ff @(posedge clk) begin
		result_q.m00        <= ent[0];
		result_q.m01        <= ent[1];
		result_q.m02        <= ent[2];
		result_q.m10        <= ent[3];
		result_q.m11        <= ent[4];
		result_q.m12        <= ent[5];
		result_q.m20        <= ent[6];
		result_q.m21        <= ent[7];
		result_q.m22        <= ent[8];
		result_q.degenerate <= deg_d[QB-1];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/core/qrm_front.sv =====
// Front end: magnitudes, pairwise products, norm and numerators (three stages).
// Depends on qrm_pkg.
`timescale 1ns / 1ps
module qrm_front import qrm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  in_t    item,
	output logic   out_valid,
	output front_t out_data
);

	logic [CW-1:0] raw [4];
	logic [CW-1:0] mfull [4];
	logic [CW-1:0] top;
	logic [SHW-1:0] sh;

	logic           vld_s1, vld_s2, vld_s3;
	logic [MW-1:0]  mag_s1 [4];
	logic [3:0]     neg_s1;
	logic           deg_s1, deg_s2;

	logic [PRW-1:0] sq_s2 [4];
	logic [SPW-1:0] xy_s2, xz_s2, xw_s2, yz_s2, yw_s2, zw_s2;

	logic [SPW:0]   p [6];
	front_t         fr_s3;

	// Component magnitudes and pre-scale amount
	always_comb begin
		raw[0] = item.comp_x;
		raw[1] = item.comp_y;
		raw[2] = item.comp_z;
		raw[3] = item.comp_w;
		top = '0;
		for (int i = 0; i < 4; i++) begin
			mfull[i] = raw[i][CW-1] ? (~raw[i] + 1'b1) : raw[i];
			if (mfull[i] > top)
				top = mfull[i];
		end
		sh = '0;
		for (int j = 1; j <= SH_MAX; j++) begin
			if (64'(top >> (j - 1)) > MAG_LIMIT)
				sh = SHW'(j);
		end
	end

	// Stage 1: scaled magnitudes, signs, zero detect
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			mag_s1[i] <= MW'(mfull[i] >> sh);
			neg_s1[i] <= raw[i][CW-1];
		end
		deg_s1 <= (top == '0);
	end

	// Stage 2: squares and signed cross products
	function automatic logic [SPW-1:0] sprod(logic [MW-1:0] a, logic [MW-1:0] b,
		logic sa, logic sb);
		logic [PRW-1:0] m;
		m = PRW'(a) * PRW'(b);
		return (sa ^ sb) ? (~{1'b0, m} + 1'b1) : {1'b0, m};
	endfunction

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++)
			sq_s2[i] <= PRW'(mag_s1[i]) * PRW'(mag_s1[i]);
		xy_s2 <= sprod(mag_s1[0], mag_s1[1], neg_s1[0], neg_s1[1]);
		xz_s2 <= sprod(mag_s1[0], mag_s1[2], neg_s1[0], neg_s1[2]);
		xw_s2 <= sprod(mag_s1[0], mag_s1[3], neg_s1[0], neg_s1[3]);
		yz_s2 <= sprod(mag_s1[1], mag_s1[2], neg_s1[1], neg_s1[2]);
		yw_s2 <= sprod(mag_s1[1], mag_s1[3], neg_s1[1], neg_s1[3]);
		zw_s2 <= sprod(mag_s1[2], mag_s1[3], neg_s1[2], neg_s1[3]);
		deg_s2 <= deg_s1;
	end

	// Off-diagonal numerators in matrix order 01, 02, 10, 12, 20, 21
	always_comb begin
		p[0] = {xy_s2[SPW-1], xy_s2} - {zw_s2[SPW-1], zw_s2};
		p[1] = {xz_s2[SPW-1], xz_s2} + {yw_s2[SPW-1], yw_s2};
		p[2] = {xy_s2[SPW-1], xy_s2} + {zw_s2[SPW-1], zw_s2};
		p[3] = {yz_s2[SPW-1], yz_s2} - {xw_s2[SPW-1], xw_s2};
		p[4] = {xz_s2[SPW-1], xz_s2} - {yw_s2[SPW-1], yw_s2};
		p[5] = {yz_s2[SPW-1], yz_s2} + {xw_s2[SPW-1], xw_s2};
	end

	// Stage 3: norm, diagonal sums, numerator magnitudes
	function automatic logic [NW-1:0] pabs(logic [SPW:0] v);
		logic [SPW:0] a;
		a = v[SPW] ? (~v + 1'b1) : v;
		return NW'(a);
	endfunction

	always_ff @(posedge clk) begin
		fr_s3.deg    <= deg_s2;
		fr_s3.n      <= NW'(sq_s2[0]) + NW'(sq_s2[1]) + NW'(sq_s2[2]) + NW'(sq_s2[3]);
		fr_s3.num[0] <= NW'(sq_s2[1]) + NW'(sq_s2[2]);
		fr_s3.num[4] <= NW'(sq_s2[0]) + NW'(sq_s2[2]);
		fr_s3.num[8] <= NW'(sq_s2[0]) + NW'(sq_s2[1]);
		fr_s3.num[1] <= pabs(p[0]);
		fr_s3.num[2] <= pabs(p[1]);
		fr_s3.num[3] <= pabs(p[2]);
		fr_s3.num[5] <= pabs(p[3]);
		fr_s3.num[6] <= pabs(p[4]);
		fr_s3.num[7] <= pabs(p[5]);
		fr_s3.neg    <= {1'b0, p[5][SPW], p[4][SPW], p[3][SPW], 1'b0, p[2][SPW],
			p[1][SPW], p[0][SPW], 1'b0};
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = fr_s3;

endmodule

// ===== rtl/core/qrm_divider.sv =====
// Pipelined restoring divider: floor(num * 2^16 / den), one quotient bit per stage.
// Depends on qrm_pkg; requires num <= den.
`timescale 1ns / 1ps
module qrm_divider import qrm_pkg::*; (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic [QB-1:0] quo
);

	logic [NW-1:0] rem_s [QB];
	logic [NW-1:0] den_s [QB];
	logic [QB-1:0] quo_s [QB];

	for (genvar g = 0; g < QB; g++) begin : g_stage
		logic [NW:0]   trial;
		logic [NW-1:0] dcur;
		logic [QB-1:0] qprev;
		logic          ge;

		// Shift in the next dividend bit (all zero) and compare
		if (g == 0) begin : g_first
			assign trial = {1'b0, num};
			assign dcur  = den;
			assign qprev = '0;
		end else begin : g_next
			assign trial = {rem_s[g-1], 1'b0};
			assign dcur  = den_s[g-1];
			assign qprev = quo_s[g-1];
		end
		assign ge = (trial >= {1'b0, dcur});

		// Remainder stays below den, so it fits NW bits
		always_ff @(posedge clk) begin
			rem_s[g] <= NW'(ge ? (trial - {1'b0, dcur}) : trial);
			den_s[g] <= dcur;
			quo_s[g] <= {qprev[QB-2:0], ge};
		end
	end

	assign quo = quo_s[QB-1];

endmodule

// ===== rtl/core/qrm_checker.sv =====
// Port-level checker for quaternion_to_rotation_matrix, bound to the top level.
// Depends on qrm_pkg and quaternion_to_rotation_matrix_defines.svh.
`timescale 1ns / 1ps
`include "quaternion_to_rotation_matrix_defines.svh"
module qrm_checker import qrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input out_t result
);

	logic acc;
	assign acc = start && !busy;

	// Every transaction yields one result at fixed latency, and only then
	`QRM_ASSERT_IMPLY(a_lat_fwd, acc, ##LATENCY done, "accepted item gave no result")
	`QRM_ASSERT_IMPLY(a_lat_back, done, $past(acc, LATENCY), "result without a transaction")
	// Degenerate result has ones on the diagonal and zero m01, m12 and m20
	`QRM_ASSERT_IMPLY(a_deg_ident, done && result.degenerate,
		result.m00 == ONE_Q14 && result.m11 == ONE_Q14 && result.m22 == ONE_Q14 &&
		result.m01 == 16'd0 && result.m12 == 16'd0 && result.m20 == 16'd0,
		"degenerate result is not identity")
	// Diagonal entries m00 and m11 stay within plus or minus one
	`QRM_ASSERT_IMPLY(a_diag_rng, done,
		result.m00 >= -16'sd16384 && result.m00 <= 16'sd16384 &&
		result.m11 >= -16'sd16384 && result.m11 <= 16'sd16384,
		"diagonal entry out of range")

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (.*);
